FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the MIDI tone controller.
// Expects clk and rst_n to be visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mntc_pkg.sv
// Package for the MIDI note to tone controller: status codes, note range
// constants and the note period ROM. No dependencies.
package mntc_pkg;

    localparam int NOTE_W    = 8;
    localparam int PERIOD_W  = 16;
    localparam int COMPARE_W = 15;
    localparam int SLOT_W    = 6;

    localparam logic [NOTE_W-1:0] NOTE_NONE  = 8'd255;
    localparam logic [NOTE_W-1:0] NOTE_LOW   = 8'd36;
    localparam logic [NOTE_W-1:0] NOTE_HIGH  = 8'd72;

    // Status codes: upper nibble for channel messages, full byte for reset
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [7:0] STATUS_SYSTEM_RESET = 8'hFF;

    // Period count for each note from the lowest table note upward
    function automatic logic [PERIOD_W-1:0] tone_period(input logic [SLOT_W-1:0] slot);
        logic [PERIOD_W-1:0] p;
        unique case (slot)
            6'd0:  p = 16'd45865;
            6'd1:  p = 16'd43290;
            6'd2:  p = 16'd40590;
            6'd3:  p = 16'd38570;
            6'd4:  p = 16'd36403;
            6'd5:  p = 16'd34360;
            6'd6:  p = 16'd32432;
            6'd7:  p = 16'd30612;
            6'd8:  p = 16'd28902;
            6'd9:  p = 16'd27273;
            6'd10: p = 16'd25742;
            6'd11: p = 16'd24295;
            6'd12: p = 16'd22932;
            6'd13: p = 16'd21647;
            6'd14: p = 16'd20294;
            6'd15: p = 16'd19285;
            6'd16: p = 16'd18203;
            6'd17: p = 16'd17180;
            6'd18: p = 16'd16216;
            6'd19: p = 16'd15306;
            6'd20: p = 16'd14493;
            6'd21: p = 16'd13636;
            6'd22: p = 16'd12871;
            6'd23: p = 16'd12148;
            6'd24: p = 16'd11467;
            6'd25: p = 16'd10823;
            6'd26: p = 16'd10216;
            6'd27: p = 16'd9642;
            6'd28: p = 16'd9101;
            6'd29: p = 16'd8590;
            6'd30: p = 16'd8108;
            6'd31: p = 16'd7653;
            6'd32: p = 16'd7224;
            6'd33: p = 16'd6818;
            6'd34: p = 16'd6436;
            6'd35: p = 16'd6074;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

FILE: hw/rtl/mntc_ifs.sv
// Valid/ready channel interfaces for the MIDI tone controller: the MIDI
// message word in and the tone state word out. Depends on mntc_pkg.
interface mntc_midi_if
    import mntc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [7:0]        status_byte;
    logic [NOTE_W-1:0] key_number;
    logic [7:0]        velocity;

    modport source (output valid, output status_byte, output key_number,
                    output velocity, input ready);
    modport sink   (input valid, input status_byte, input key_number,
                    input velocity, output ready);
endinterface

interface mntc_tone_if
    import mntc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 tone_on;
    logic [PERIOD_W-1:0]  period;
    logic [COMPARE_W-1:0] compare;
    logic [NOTE_W-1:0]    current_note;

    modport source (output valid, output tone_on, output period, output compare,
                    output current_note, input ready);
    modport sink   (input valid, input tone_on, input period, input compare,
                    input current_note, output ready);
endinterface

FILE: hw/rtl/midi_note_tone_controller_top.sv
// Top level of the monophonic MIDI note to PWM tone controller.
// Depends on mntc_pkg, mntc_ifs.sv and assert_macros.svh.
//
//   channel    dir   word
//   midi_in    in    status_byte, key_number, velocity
//   tone_out   out   tone_on, period, compare, current_note
//
// One message per cycle unless the output stalls: decode, ROM lookup and the state update sit
// between the input handshake and the output register, so every accepted
// word yields its tone word on the next cycle. Reset leaves no note held
// and the tone stopped with zero period and compare. A stalled output word
// holds in its register; a new message is taken whenever that register is
// empty or is being drained in the same cycle.
`include "assert_macros.svh"

module midi_note_tone_controller_top
    import mntc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mntc_midi_if.sink    midi_in,
    mntc_tone_if.source  tone_out
);

    // Held tone state
    logic [NOTE_W-1:0]    held_note_reg, held_note_next;
    logic                 running_reg, running_next;
    logic [PERIOD_W-1:0]  period_reg, period_next;
    logic [COMPARE_W-1:0] compare_reg, compare_next;

    // Output word register
    logic                 out_valid_reg;
    logic                 out_tone_on_reg;
    logic [PERIOD_W-1:0]  out_period_reg;
    logic [COMPARE_W-1:0] out_compare_reg;
    logic [NOTE_W-1:0]    out_note_reg;

    logic                 in_accept;
    logic [3:0]           kind;
    logic                 note_on;
    logic                 silence;
    logic                 touched;
    logic                 in_table;
    logic [NOTE_W-1:0]    slot_full;
    logic [PERIOD_W-1:0]  rom_period;

    // Take a word when the output register is free or drains now
    assign midi_in.ready = !out_valid_reg || tone_out.ready;
    assign in_accept     = midi_in.valid && midi_in.ready;

    // Decode the status byte, ignoring the channel nibble except for system reset
    assign kind    = midi_in.status_byte[7:4];
    assign note_on = (kind == KIND_NOTE_ON);
    assign silence = (kind == KIND_NOTE_OFF) || (midi_in.status_byte == STATUS_SYSTEM_RESET);

    // Work out the held note after this word
    always_comb
    begin
        held_note_next = held_note_reg;
        touched        = 1'b0;
        priority if (note_on && (midi_in.velocity != 8'd0))
        begin
            held_note_next = midi_in.key_number;
            touched        = 1'b1;
        end
        else if (note_on && (midi_in.key_number == held_note_reg))
        begin
            held_note_next = NOTE_NONE;
            touched        = 1'b1;
        end
        else if (silence)
        begin
            held_note_next = NOTE_NONE;
            touched        = 1'b1;
        end
        else
        begin
            // Keep the held note for any other word
            held_note_next = held_note_reg;
            touched        = 1'b0;
        end
    end

    // Look up the period of the new note
    assign in_table   = (held_note_next >= NOTE_LOW) && (held_note_next < NOTE_HIGH);
    assign slot_full  = held_note_next - NOTE_LOW;
    assign rom_period = tone_period(slot_full[SLOT_W-1:0]);

    // Update the tone generator settings
    always_comb
    begin
        running_next = running_reg;
        period_next  = period_reg;
        compare_next = compare_reg;
        if (touched && (held_note_next == NOTE_NONE))
        begin
            running_next = 1'b0;
        end
        if (touched && in_table)
        begin
            period_next  = rom_period;
            compare_next = rom_period[PERIOD_W-1:1];
            running_next = 1'b1;
        end
    end

    // Advance state and load the output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_note_reg <= NOTE_NONE;
            running_reg   <= 1'b0;
            period_reg    <= '0;
            compare_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                held_note_reg <= held_note_next;
                running_reg   <= running_next;
                period_reg    <= period_next;
                compare_reg   <= compare_next;
                out_valid_reg <= 1'b1;
            end
            else if (tone_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload, loaded on accept only
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_tone_on_reg <= running_next;
            out_period_reg  <= period_next;
            out_compare_reg <= compare_next;
            out_note_reg    <= held_note_next;
        end
    end

    assign tone_out.valid        = out_valid_reg;
    assign tone_out.tone_on      = out_tone_on_reg;
    assign tone_out.period       = out_period_reg;
    assign tone_out.compare      = out_compare_reg;
    assign tone_out.current_note = out_note_reg;

    // Checks
    `ASSERT_IMPLY(a_cmp_half, running_reg, compare_reg == period_reg[PERIOD_W-1:1],
        "compare is not half the period")
    `ASSERT_IMPLY(a_table_runs, (held_note_reg >= NOTE_LOW) && (held_note_reg < NOTE_HIGH),
        running_reg, "table note held but tone stopped")
    `ASSERT_NEXT(a_off_silent, in_accept && silence,
        out_valid_reg && (out_note_reg == NOTE_NONE) && !out_tone_on_reg,
        "note off did not silence")

endmodule
